// File: design/scapdu_pkg.sv
`default_nettype none
package scapdu_pkg;
    localparam int MaxData = 16;
    localparam int AddrW = $clog2(MaxData);
    localparam int CntW = $clog2(MaxData + 1);

    typedef enum logic [3:0] {
        t_st_idle, t_st_atr, t_st_ver, t_st_stat, t_st_ack, t_st_rdreq, t_st_rddat,
        t_st_cpreq, t_st_cpwr
    } t_state;

    localparam logic [7:0] ClaProp = 8'h80;
    localparam logic [7:0] InsVer = 8'h00;
    localparam logic [7:0] InsStore = 8'h01;
    localparam logic [7:0] InsRead = 8'h02;
    localparam logic [7:0] SwOk = 8'h90;
    localparam logic [7:0] SwLen = 8'h6C;
    localparam logic [7:0] SwIns = 8'h6D;
    localparam logic [7:0] SwCla = 8'h6E;

    function automatic logic [7:0] atr_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0: b = 8'h3B;
            4'd1: b = 8'h0B;
            4'd2: b = "T";
            4'd3: b = "r";
            4'd4: b = "a";
            4'd5: b = "n";
            4'd6: b = "s";
            4'd7: b = "a";
            4'd8: b = "c";
            4'd9: b = "t";
            4'd10: b = "i";
            4'd11: b = "o";
            4'd12: b = "n";
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ver_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = "1";
            2'd1: b = ".";
            2'd2: b = "0";
            default: b = "2";
        endcase
        return b;
    endfunction
endpackage
`default_nettype wire

// File: design/scapdu_if.sv
`default_nettype none
interface scapdu_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic [7:0] rx_byte;
    modport source(output valid, req_type, rx_byte, input ready);
    modport sink(input valid, req_type, rx_byte, output ready);
endinterface

interface scapdu_rsp_if;
    logic valid;
    logic ready;
    logic [7:0] tx_byte;
    logic last;
    modport source(output valid, tx_byte, last, input ready);
    modport sink(input valid, tx_byte, last, output ready);
endinterface
`default_nettype wire

// File: design/smartcard_apdu_store_responder_unit.sv
// Card side of a T=0 command exchange with a journaled 16-byte data store.
// i_req (sink): one request per item; req_type 0 asks for the answer-to-reset,
// req_type 1 carries one byte from the reader. o_rsp (source): bytes to the
// reader, last marks the final byte of one request's reply.
// One request at a time. A header byte with no reply leaves the unit idle, so
// header bytes can follow back to back. A reply (ATR, version, status) shows
// its first byte in the cycle after the request and then one byte per cycle
// when the receiver takes them; the ATR has 13 bytes. A read fetches each data
// byte from the store memory and then sends it. Committing a store copies the
// journal into the store memory, each byte by a journal read and then a store
// write, before 90 00 is sent.
// Data, journal and store contents live in synchronous RAMs with registered
// read data. Reset clears the command state, stored length and journal flag;
// memory contents are left alone and are only read once written.
// When the receiver stalls, the reply byte is held in the output register and
// no further request is taken until the reply is complete.
`default_nettype none
module smartcard_apdu_store_responder_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    scapdu_req_if.sink        i_req,
    scapdu_rsp_if.source      o_rsp
);
    localparam int AW = scapdu_pkg::AddrW;
    localparam int CW = scapdu_pkg::CntW;

    scapdu_pkg::t_state r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0] r_cla, n_cla, r_ins, n_ins, r_len, n_len;
    logic [CW-1:0] r_slen, n_slen;
    logic r_jfull, n_jfull;
    logic [CW-1:0] r_idx, n_idx;
    logic [7:0] r_s2, n_s2;
    logic [7:0] r_tx, n_tx;
    logic r_last, n_last, r_vld, n_vld;

    // journal RAM (data bytes, written on receive); length kept in r_len
    logic [7:0] r_jmem [scapdu_pkg::MaxData];
    logic [7:0] r_smem [scapdu_pkg::MaxData];
    logic [7:0] r_jrd, r_srd;
    logic j_we; logic [AW-1:0] j_wa, j_ra;
    logic s_we; logic [AW-1:0] s_wa, s_ra;

    always_ff @(posedge i_clk) begin
        if (j_we) r_jmem[j_wa] <= i_req.rx_byte;
        r_jrd <= r_jmem[j_ra];
        if (s_we) r_smem[s_wa] <= r_jrd;
        r_srd <= r_smem[s_ra];
    end

    wire take = i_req.valid && i_req.ready;
    wire out_free = !r_vld || o_rsp.ready;
    assign i_req.ready = (r_state == scapdu_pkg::t_st_idle) && out_free;
    assign o_rsp.valid = r_vld;
    assign o_rsp.tx_byte = r_tx;
    assign o_rsp.last = r_last;

    always_comb begin
        n_state = r_state; n_phase = r_phase; n_cnt = r_cnt; n_cla = r_cla;
        n_ins = r_ins; n_len = r_len; n_slen = r_slen; n_jfull = r_jfull;
        n_idx = r_idx; n_s2 = r_s2; n_tx = r_tx; n_last = r_last;
        n_vld = r_vld && !o_rsp.ready;
        j_we = 1'b0; j_wa = r_cnt[AW-1:0]; j_ra = r_idx[AW-1:0];
        s_we = 1'b0; s_wa = r_idx[AW-1:0] - AW'(1); s_ra = r_idx[AW-1:0];
        case (r_state)
            scapdu_pkg::t_st_idle: begin
                if (take) begin
                    if (!i_req.req_type) begin
                        n_phase = 3'd0; n_cnt = '0;
                        n_tx = scapdu_pkg::atr_byte(4'd0); n_last = 1'b0; n_vld = 1'b1;
                        n_idx = CW'(1); n_state = scapdu_pkg::t_st_atr;
                    end else if (r_phase == 3'd5) begin
                        j_we = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                        if ({3'b0, n_cnt} >= r_len) begin
                            n_phase = 3'd0; n_cnt = '0; n_jfull = 1'b1;
                            n_idx = '0; n_state = scapdu_pkg::t_st_cpreq;
                        end
                    end else begin
                        case (r_phase)
                            3'd0: begin n_cla = i_req.rx_byte; n_phase = 3'd1; end
                            3'd1: begin n_ins = i_req.rx_byte; n_phase = 3'd2; end
                            3'd2: n_phase = 3'd3;
                            3'd3: n_phase = 3'd4;
                            3'd4: begin
                                n_len = i_req.rx_byte; n_phase = 3'd0;
                                n_vld = 1'b1; n_last = 1'b0;
                                n_state = scapdu_pkg::t_st_stat;
                                if (r_cla != scapdu_pkg::ClaProp) begin
                                    n_tx = scapdu_pkg::SwCla; n_s2 = 8'h00;
                                end else if (r_ins == scapdu_pkg::InsVer) begin
                                    if (i_req.rx_byte != 8'd4) begin
                                        n_tx = scapdu_pkg::SwLen; n_s2 = 8'd4;
                                    end else begin
                                        n_tx = r_ins; n_idx = '0;
                                        n_state = scapdu_pkg::t_st_ver;
                                    end
                                end else if (r_ins == scapdu_pkg::InsStore) begin
                                    if (i_req.rx_byte > 8'(scapdu_pkg::MaxData)) begin
                                        n_tx = scapdu_pkg::SwLen;
                                        n_s2 = 8'(scapdu_pkg::MaxData);
                                    end else begin
                                        n_tx = r_ins;
                                        if (i_req.rx_byte == 8'd0) begin
                                            n_slen = '0; n_state = scapdu_pkg::t_st_ack;
                                        end else begin
                                            n_last = 1'b1; n_cnt = '0; n_phase = 3'd5;
                                            n_state = scapdu_pkg::t_st_idle;
                                        end
                                    end
                                end else if (r_ins == scapdu_pkg::InsRead) begin
                                    if (i_req.rx_byte != {3'b0, r_slen}) begin
                                        n_tx = scapdu_pkg::SwLen; n_s2 = {3'b0, r_slen};
                                    end else begin
                                        n_tx = r_ins; n_idx = '0;
                                        n_state = (r_slen == '0) ? scapdu_pkg::t_st_ack
                                                                 : scapdu_pkg::t_st_rdreq;
                                    end
                                end else begin
                                    n_tx = scapdu_pkg::SwIns; n_s2 = 8'h00;
                                end
                            end
                            default: n_phase = 3'd0;
                        endcase
                    end
                end
            end
            scapdu_pkg::t_st_atr: if (out_free) begin
                n_tx = scapdu_pkg::atr_byte(r_idx[3:0]); n_vld = 1'b1;
                n_last = (r_idx == CW'(12));
                n_idx = r_idx + CW'(1);
                if (n_last) n_state = scapdu_pkg::t_st_idle;
            end
            scapdu_pkg::t_st_ver: if (out_free) begin
                n_tx = scapdu_pkg::ver_byte(r_idx[1:0]); n_vld = 1'b1; n_last = 1'b0;
                n_idx = r_idx + CW'(1);
                if (r_idx == CW'(3)) n_state = scapdu_pkg::t_st_ack;
            end
            scapdu_pkg::t_st_ack: if (out_free) begin
                n_tx = scapdu_pkg::SwOk; n_s2 = 8'h00; n_vld = 1'b1; n_last = 1'b0;
                n_state = scapdu_pkg::t_st_stat;
            end
            scapdu_pkg::t_st_stat: if (out_free) begin
                n_tx = r_s2; n_vld = 1'b1; n_last = 1'b1;
                n_state = scapdu_pkg::t_st_idle;
            end
            scapdu_pkg::t_st_rdreq: begin
                // issue read of r_idx; data valid next cycle
                n_state = scapdu_pkg::t_st_rddat;
            end
            scapdu_pkg::t_st_rddat: if (out_free) begin
                n_tx = r_srd; n_vld = 1'b1; n_last = 1'b0;
                n_idx = r_idx + CW'(1);
                n_state = (n_idx == r_slen) ? scapdu_pkg::t_st_ack
                                            : scapdu_pkg::t_st_rdreq;
            end
            scapdu_pkg::t_st_cpreq: begin
                n_idx = r_idx + CW'(1);
                n_state = scapdu_pkg::t_st_cpwr;
            end
            scapdu_pkg::t_st_cpwr: begin
                // r_jrd holds journal[r_idx-1]
                s_we = 1'b1;
                if (r_idx == r_len[CW-1:0]) begin
                    n_slen = r_len[CW-1:0]; n_jfull = 1'b0;
                    n_state = scapdu_pkg::t_st_ack;
                end else begin
                    n_state = scapdu_pkg::t_st_cpreq;
                end
            end
            default: n_state = scapdu_pkg::t_st_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scapdu_pkg::t_st_idle; r_phase <= '0; r_cnt <= '0;
            r_cla <= '0; r_ins <= '0; r_len <= '0; r_slen <= '0; r_jfull <= 1'b0;
            r_idx <= '0; r_vld <= 1'b0;
        end else begin
            r_state <= n_state; r_phase <= n_phase; r_cnt <= n_cnt;
            r_cla <= n_cla; r_ins <= n_ins; r_len <= n_len; r_slen <= n_slen;
            r_jfull <= n_jfull; r_idx <= n_idx; r_vld <= n_vld;
        end
        r_tx <= n_tx; r_last <= n_last; r_s2 <= n_s2;
    end
endmodule
`default_nettype wire

// File: design/scapdu_checker.sv
`default_nettype none
module scapdu_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire logic i_rsp_last,
    input wire logic [7:0] i_rsp_tx
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_tx) && $stable(i_rsp_last))
        else $error("reply byte changed while stalled");
    // a request is only taken when the output register is free
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready |-> !i_rsp_valid || i_rsp_ready)
        else $error("request taken while reply stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_last |-> !i_req_ready)
        else $error("request taken mid reply");
endmodule

bind smartcard_apdu_store_responder_unit scapdu_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(i_req.valid), .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready), .i_rsp_last(o_rsp.last),
    .i_rsp_tx(o_rsp.tx_byte)
);
`default_nettype wire

// File: tb/scapdu_tb_pkg.sv
`timescale 1ns / 100ps
package scapdu_tb_pkg;
    localparam logic REQ_ATR  = 1'b0;
    localparam logic REQ_BYTE = 1'b1;
endpackage

// File: tb/tb_smartcard_apdu_store_responder_unit.sv
`timescale 1ns / 100ps
module tb_smartcard_apdu_store_responder_unit;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_card_byte;

    typedef struct {
        logic       req_type;
        logic [7:0] rx_byte;
        int         n_fixed;      // typed-in leading reply bytes; 0 means model only
        logic [7:0] fixed [4];
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    scapdu_req_if req_ch ();
    scapdu_rsp_if rsp_ch ();

    smartcard_apdu_store_responder_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // card model state
    logic [2:0] mdl_phase;
    logic [4:0] mdl_count;
    logic [7:0] mdl_cla, mdl_ins, mdl_len;
    logic [7:0] mdl_rxbuf [scapdu_pkg::MaxData];
    logic [4:0] mdl_stored_len;
    logic [7:0] mdl_stored [scapdu_pkg::MaxData];

    t_card_byte reply_q[$];
    int errors = 0;
    int tbl_errors = 0;
    logic rsp_stall = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void push_reply(ref t_card_byte q[$], input logic [7:0] b);
        t_card_byte e;
        e.tx_byte = b;
        e.last = 1'b0;
        q.push_back(e);
    endfunction

    task automatic card_predict(input logic rtype, input logic [7:0] b);
        t_card_byte r[$];
        string atr;
        atr = "Transaction";
        if (rtype == scapdu_tb_pkg::REQ_ATR) begin
            mdl_phase = 0;
            mdl_count = 0;
            push_reply(r, 8'h3B);
            push_reply(r, 8'h0B);
            for (int i = 0; i < 11; i++) push_reply(r, atr[i]);
        end else if (mdl_phase == 5) begin
            if (mdl_count < scapdu_pkg::MaxData) mdl_rxbuf[mdl_count] = b;
            mdl_count++;
            if (mdl_count >= mdl_len || mdl_count >= scapdu_pkg::MaxData) begin
                mdl_stored_len = mdl_len[4:0];
                for (int i = 0; i < mdl_len; i++) mdl_stored[i] = mdl_rxbuf[i];
                mdl_phase = 0;
                mdl_count = 0;
                push_reply(r, scapdu_pkg::SwOk);
                push_reply(r, 8'h00);
            end
        end else begin
            case (mdl_phase)
                0: begin mdl_cla = b; mdl_phase = 1; end
                1: begin mdl_ins = b; mdl_phase = 2; end
                2: mdl_phase = 3;
                3: mdl_phase = 4;
                default: begin
                    mdl_len = b;
                    mdl_phase = 0;
                    if (mdl_cla != scapdu_pkg::ClaProp) begin
                        push_reply(r, scapdu_pkg::SwCla); push_reply(r, 8'h00);
                    end else if (mdl_ins == scapdu_pkg::InsVer) begin
                        if (mdl_len != 4) begin
                            push_reply(r, scapdu_pkg::SwLen); push_reply(r, 8'h04);
                        end else begin
                            push_reply(r, mdl_ins);
                            push_reply(r, "1"); push_reply(r, ".");
                            push_reply(r, "0"); push_reply(r, "2");
                            push_reply(r, scapdu_pkg::SwOk); push_reply(r, 8'h00);
                        end
                    end else if (mdl_ins == scapdu_pkg::InsStore) begin
                        if (mdl_len > scapdu_pkg::MaxData) begin
                            push_reply(r, scapdu_pkg::SwLen);
                            push_reply(r, 8'(scapdu_pkg::MaxData));
                        end else begin
                            push_reply(r, mdl_ins);
                            if (mdl_len == 0) begin
                                mdl_stored_len = 0;
                                push_reply(r, scapdu_pkg::SwOk); push_reply(r, 8'h00);
                            end else begin
                                mdl_count = 0;
                                mdl_phase = 5;
                            end
                        end
                    end else if (mdl_ins == scapdu_pkg::InsRead) begin
                        if (mdl_len != {3'b0, mdl_stored_len}) begin
                            push_reply(r, scapdu_pkg::SwLen);
                            push_reply(r, {3'b0, mdl_stored_len});
                        end else begin
                            push_reply(r, mdl_ins);
                            for (int i = 0; i < mdl_stored_len; i++)
                                push_reply(r, mdl_stored[i]);
                            push_reply(r, scapdu_pkg::SwOk); push_reply(r, 8'h00);
                        end
                    end else begin
                        push_reply(r, scapdu_pkg::SwIns); push_reply(r, 8'h00);
                    end
                end
            endcase
        end
        if (r.size() > 0) r[$].last = 1'b1;
        foreach (r[i]) reply_q.push_back(r[i]);
    endtask

    // Sends one request; optional typed-in reply is checked against the model too.
    task automatic send_req(input logic rtype, input logic [7:0] b, input int n_fixed,
                            input logic [7:0] fixed [4]);
        int base;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rtype;
        req_ch.rx_byte  <= b;
        do @(posedge i_clk); while (!req_ch.ready);
        base = reply_q.size();
        card_predict(rtype, b);
        if (n_fixed > 0) begin
            if (reply_q.size() - base < n_fixed) begin
                $error("reply length expected %0d actual %0d", n_fixed,
                       reply_q.size() - base);
                tbl_errors++;
            end else begin
                for (int i = 0; i < n_fixed; i++)
                    if (reply_q[base + i].tx_byte != fixed[i]) begin
                        $error("table tx_byte expected %h actual %h", fixed[i],
                               reply_q[base + i].tx_byte);
                        tbl_errors++;
                    end
            end
        end
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_card_byte exp_b;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (reply_q.size() == 0) begin
                $error("unexpected reply byte %h", rsp_ch.tx_byte);
                errors++;
            end else begin
                exp_b = reply_q.pop_front();
                if (rsp_ch.tx_byte !== exp_b.tx_byte) begin
                    $error("tx_byte expected %h actual %h", exp_b.tx_byte, rsp_ch.tx_byte);
                    errors++;
                end
                if (rsp_ch.last !== exp_b.last) begin
                    $error("last expected %b actual %b", exp_b.last, rsp_ch.last);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern: held stall windows alternate with windows where ready is random
    always @(posedge i_clk) begin
        int cyc;
        cyc = $urandom_range(0, 99);
        if (!rsp_stall && cyc < 3) rsp_stall <= 1'b1;
        else if (rsp_stall && cyc < 40) rsp_stall <= 1'b0;
        rsp_ch.ready <= rsp_stall ? 1'b0 : ($urandom_range(0, 3) != 0);
    end

    task automatic send_header(input logic [7:0] cla, input logic [7:0] ins,
                               input logic [7:0] len);
        logic [7:0] none [4];
        send_req(scapdu_tb_pkg::REQ_BYTE, cla, 0, none);
        send_req(scapdu_tb_pkg::REQ_BYTE, ins, 0, none);
        send_req(scapdu_tb_pkg::REQ_BYTE, 8'($urandom), 0, none);
        send_req(scapdu_tb_pkg::REQ_BYTE, 8'($urandom), 0, none);
        send_req(scapdu_tb_pkg::REQ_BYTE, len, 0, none);
    endtask

    t_stim_row table_rows [$];

    function automatic t_stim_row mk(input logic rt, input logic [7:0] b, input int n,
                                     input logic [7:0] f0, input logic [7:0] f1);
        t_stim_row s;
        s.req_type = rt; s.rx_byte = b; s.n_fixed = n;
        s.fixed[0] = f0; s.fixed[1] = f1; s.fixed[2] = 0; s.fixed[3] = 0;
        return s;
    endfunction

    initial begin
        logic [7:0] none [4];
        int burst;
        int n_items;
        int len;
        mdl_phase = 0;
        mdl_count = 0;
        mdl_cla = 0;
        mdl_ins = 0;
        mdl_len = 0;
        mdl_stored_len = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = scapdu_tb_pkg::REQ_ATR;
        req_ch.rx_byte = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes before any ATR, unknown class
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'hFF, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h00, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'hAA, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h55, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h00, 2, scapdu_pkg::SwCla, 8'h00));
        // read with zero length right after reset: stored length is zero
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, scapdu_pkg::ClaProp, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, scapdu_pkg::InsRead, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h00, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'hFF, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h00, 3, scapdu_pkg::InsRead,
                                scapdu_pkg::SwOk));
        // unknown instruction
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, scapdu_pkg::ClaProp, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'hFF, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h01, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h02, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h04, 2, scapdu_pkg::SwIns, 8'h00));
        // version with wrong length, then power-on mid-command
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, scapdu_pkg::ClaProp, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, scapdu_pkg::InsVer, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h00, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'h00, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, 8'hFF, 2, scapdu_pkg::SwLen, 8'h04));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_BYTE, scapdu_pkg::ClaProp, 0, 0, 0));
        table_rows.push_back(mk(scapdu_tb_pkg::REQ_ATR, 8'hFF, 2, 8'h3B, 8'h0B));
        foreach (table_rows[i])
            send_req(table_rows[i].req_type, table_rows[i].rx_byte, table_rows[i].n_fixed,
                     table_rows[i].fixed);

        // version ok, store too long, store empty, full store + read back
        send_header(scapdu_pkg::ClaProp, scapdu_pkg::InsVer, 8'd4);
        send_header(scapdu_pkg::ClaProp, scapdu_pkg::InsStore, 8'd17);
        send_header(scapdu_pkg::ClaProp, scapdu_pkg::InsStore, 8'd0);
        send_header(scapdu_pkg::ClaProp, scapdu_pkg::InsStore, 8'd16);
        for (int i = 0; i < 16; i++)
            send_req(scapdu_tb_pkg::REQ_BYTE, (i % 2) ? 8'hFF : 8'h00, 0, none);
        send_header(scapdu_pkg::ClaProp, scapdu_pkg::InsRead, 8'd16);
        // pause until the card has answered everything
        wait_drained();

        n_items = 0;
        while (n_items < 220) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && n_items < 220; k++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_req(($urandom_range(0, 3) == 0) ? scapdu_tb_pkg::REQ_ATR
                                                             : scapdu_tb_pkg::REQ_BYTE,
                                 8'($urandom), 0, none);
                        n_items++;
                    end
                    1, 2: begin
                        send_header(scapdu_pkg::ClaProp,
                                    ($urandom_range(0, 1)) ? scapdu_pkg::InsVer
                                                           : 8'($urandom),
                                    ($urandom_range(0, 1)) ? 8'd4 : 8'($urandom));
                        n_items += 5;
                    end
                    3, 4, 5: begin
                        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20)
                                                          : $urandom_range(1, 6);
                        send_header(scapdu_pkg::ClaProp, scapdu_pkg::InsStore, 8'(len));
                        if (len <= scapdu_pkg::MaxData) begin
                            // occasionally cut short by a power-on
                            for (int i = 0; i < len; i++) begin
                                if ($urandom_range(0, 60) == 0) begin
                                    send_req(scapdu_tb_pkg::REQ_ATR, 8'($urandom), 0, none);
                                    break;
                                end
                                send_req(scapdu_tb_pkg::REQ_BYTE, 8'($urandom), 0, none);
                            end
                            n_items += len;
                        end
                        n_items += 5;
                    end
                    default: begin
                        send_header(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                : scapdu_pkg::ClaProp,
                                    scapdu_pkg::InsRead,
                                    ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                : {3'b0, mdl_stored_len});
                        n_items += 5;
                    end
                endcase
            end
            idle_gap($urandom_range(0, 40));
        end

        req_ch.valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && tbl_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: files.f
design/scapdu_pkg.sv
design/scapdu_if.sv
design/smartcard_apdu_store_responder_unit.sv
design/scapdu_checker.sv
tb/scapdu_tb_pkg.sv
tb/tb_smartcard_apdu_store_responder_unit.sv
